// File: rtl/assert_macros.svh
// assertion macros shared by the controller and datapath modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock outside reset
`define AST_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// same-cycle implication
`define AST_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hfmc_pkg.sv
// package: widths, constants, state, command and status types of the frequency counter
`timescale 1ns / 1ps
`default_nettype none
package hfmc_pkg;
    localparam int KEY_W     = 40;
    localparam int CNT_W     = 16;
    localparam int TIE_W     = 13;
    localparam int SIZE_W    = 13;
    localparam int BIT_W     = $clog2(KEY_W);
    localparam int SLOTS_DEF = 4096;
    localparam int SIZE_RST  = 4096;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [TIE_W-1:0] TIE_MAX = '1;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_MOD, S_PRD, S_PCMP, S_SRD, S_SCMP, S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic rd;
        logic probe;
        logic scan_init;
        logic scan_rd;
        logic scan_cmp;
        logic emit;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic probe_done;
        logic scan_last;
        logic clr_last;
        logic last_flag;
        logic out_busy;
    } t_sts;
endpackage
`default_nettype wire

// File: rtl/hfmc_ctrl.sv
// controller: sequences modulo, probe walk, scan, report and table clear
`timescale 1ns / 1ps
`default_nettype none
module hfmc_ctrl
    import hfmc_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    `include "assert_macros.svh"

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE: if (i_valid) n_state = S_MOD;
            S_MOD:  if (i_sts.mod_done) n_state = S_PRD;
            S_PRD:  n_state = S_PCMP;
            S_PCMP: begin
                if (!i_sts.probe_done) n_state = S_PRD;
                else if (i_sts.last_flag) n_state = S_SRD;
                else n_state = S_IDLE;
            end
            S_SRD:  n_state = S_SCMP;
            S_SCMP: n_state = i_sts.scan_last ? S_EMIT : S_SRD;
            S_EMIT: if (!i_sts.out_busy) n_state = S_CLR;
            default: n_state = S_CLR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_CLR:  o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            S_MOD:  o_cmd.mod_step = 1'b1;
            S_PRD:  o_cmd.rd = 1'b1;
            S_PCMP: begin
                o_cmd.probe     = 1'b1;
                o_cmd.scan_init = i_sts.probe_done & i_sts.last_flag;
            end
            S_SRD:  o_cmd.scan_rd = 1'b1;
            S_SCMP: o_cmd.scan_cmp = 1'b1;
            S_EMIT: o_cmd.emit = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

    `AST_IMPL(a_cmp_after_rd, r_state == S_PCMP, $past(r_state) == S_PRD, "probe without read")
    `AST_NEXT(a_emit_to_clr, o_cmd.emit, r_state == S_CLR, "report not followed by clear")
    `AST_IMPL(a_idle_entry, (r_state == S_IDLE) && ($past(r_state) != S_IDLE),
              ($past(r_state) == S_CLR) || ($past(r_state) == S_PCMP), "bad idle entry")
endmodule
`default_nettype wire

// File: rtl/hfmc_dp.sv
// datapath: serial modulo, slot memory, probe compare, scan and result register
`timescale 1ns / 1ps
`default_nettype none
module hfmc_dp
    import hfmc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire  [KEY_W-1:0]        i_key,
    input  wire                     i_last,
    input  wire                     i_cfg_we,
    input  wire  [SIZE_W-1:0]       i_cfg_data,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  wire                     i_stall,
    output logic                    o_valid,
    output logic [KEY_W-1:0]        o_top_key,
    output logic [CNT_W-1:0]        o_top_count,
    output logic [TIE_W-1:0]        o_tie_count,
    output logic                    o_dropped
);
    `include "assert_macros.svh"

    localparam int IW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int MW    = KEY_W + CNT_W;
    localparam int N_RST = (SIZE_RST > SLOTS) ? SLOTS : SIZE_RST;

    logic [MW-1:0]    r_mem [SLOTS];
    logic [MW-1:0]    r_rd;
    logic [CW-1:0]    r_n, n_n;
    logic [KEY_W-1:0] r_key, r_div, r_bkey;
    logic             r_last, r_ovf, r_ov;
    logic [BIT_W-1:0] r_bit;
    logic [CW-1:0]    r_rem, n_rem, r_step;
    logic [IW-1:0]    r_pos, n_pos, r_idx;
    logic [CNT_W-1:0] r_best, r_otc;
    logic [TIE_W-1:0] r_ties, r_ott;
    logic [KEY_W-1:0] r_otk;
    logic             r_odr;

    logic [CW:0]      sh, diff;
    logic [CW-1:0]    pinc;
    logic [KEY_W-1:0] rd_key;
    logic [CNT_W-1:0] rd_cnt, n_cnt;
    logic             hit_empty, hit_match, giveup;
    logic             we;
    logic [IW-1:0]    waddr, raddr;
    logic [MW-1:0]    wdata;

    // clamp the configured size into 1..SLOTS
    always_comb begin
        if (i_cfg_data == '0) n_n = CW'(1);
        else if (32'(i_cfg_data) > 32'(SLOTS)) n_n = CW'(SLOTS);
        else n_n = CW'(i_cfg_data);
    end

    // restoring modulo, one key bit per cycle, msb first
    assign sh    = {r_rem, r_div[KEY_W-1]};
    assign diff  = sh - {1'b0, r_n};
    assign n_rem = (sh >= {1'b0, r_n}) ? diff[CW-1:0] : sh[CW-1:0];

    assign rd_key    = r_rd[MW-1:CNT_W];
    assign rd_cnt    = r_rd[CNT_W-1:0];
    assign hit_empty = rd_cnt == '0;
    assign hit_match = rd_key == r_key;
    assign giveup    = (r_step + CW'(1)) == r_n;
    assign n_cnt     = hit_empty ? CNT_W'(1) : ((rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 1'b1);
    assign pinc      = CW'(r_pos) + CW'(1);
    assign n_pos     = (pinc == r_n) ? '0 : pinc[IW-1:0];

    assign we    = (i_cmd.probe & (hit_empty | hit_match)) | i_cmd.clr_step;
    assign waddr = i_cmd.clr_step ? r_idx : r_pos;
    assign wdata = i_cmd.clr_step ? '0 : {r_key, n_cnt};
    assign raddr = i_cmd.scan_rd ? r_idx : r_pos;

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (i_cmd.rd | i_cmd.scan_rd) r_rd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= CW'(N_RST);
            r_ovf <= 1'b0;
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_we) r_n <= n_n;
            if (i_cmd.probe & !(hit_empty | hit_match) & giveup) r_ovf <= 1'b1;
            else if (i_cmd.emit) r_ovf <= 1'b0;
            if (i_cmd.scan_init | i_cmd.emit) r_idx <= '0;
            else if (i_cmd.clr_step | i_cmd.scan_cmp) r_idx <= r_idx + 1'b1;
            if (i_cmd.emit) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_key;
            r_div  <= i_key;
            r_last <= i_last;
            r_rem  <= '0;
            r_bit  <= '0;
        end
        if (i_cmd.mod_step) begin
            r_div <= {r_div[KEY_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_bit <= r_bit + 1'b1;
            r_pos <= n_rem[IW-1:0];
            r_step <= '0;
        end
        if (i_cmd.probe) begin
            r_pos  <= n_pos;
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.scan_init) begin
            r_best <= '0;
            r_ties <= '0;
            r_bkey <= '0;
        end
        if (i_cmd.scan_cmp) begin
            if (rd_cnt > r_best) begin
                r_best <= rd_cnt;
                r_ties <= TIE_W'(1);
                r_bkey <= rd_key;
            end else if ((rd_cnt == r_best) && !hit_empty) begin
                if (r_ties != TIE_MAX) r_ties <= r_ties + 1'b1;
                if (rd_key < r_bkey) r_bkey <= rd_key;
            end
        end
        if (i_cmd.emit) begin
            r_otk <= r_bkey;
            r_otc <= r_best;
            r_ott <= r_ties;
            r_odr <= r_ovf;
        end
    end

    assign o_sts.mod_done   = r_bit == BIT_W'(KEY_W - 1);
    assign o_sts.probe_done = hit_empty | hit_match | giveup;
    assign o_sts.scan_last  = (CW'(r_idx) + CW'(1)) == r_n;
    assign o_sts.clr_last   = r_idx == IW'(SLOTS - 1);
    assign o_sts.last_flag  = r_last;
    assign o_sts.out_busy   = r_ov & i_stall;

    assign o_valid     = r_ov;
    assign o_top_key   = r_otk;
    assign o_top_count = r_otc;
    assign o_tie_count = r_ott;
    assign o_dropped   = r_odr;

    `AST_ALWAYS(a_n_range, (r_n != '0) && (32'(r_n) <= 32'(SLOTS)), "table size out of range")
    `AST_IMPL(a_pos_range, i_cmd.probe, CW'(r_pos) < r_n, "probe slot beyond table")
    `AST_NEXT(a_ovf_clr, i_cmd.emit, !r_ovf && r_ov, "drop flag kept after report")
endmodule
`default_nettype wire

// File: rtl/hash_frequency_mode_counter.sv
// per key: a load in idle, a modulo step per key bit, then a read and a compare per probe slot visited
// a last key adds a scan (read, compare per used slot), the result load and a full SLOTS clear
// a new key is taken only once the last is done, bound by the serial modulo and the probe walk
// reset: control clears at once, then all SLOTS slots are cleared before the first transfer
// table size resets to 4096 (clamped to SLOTS), drop flag resets to zero
`timescale 1ns / 1ps
`default_nettype none
module hash_frequency_mode_counter
    import hfmc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire  [KEY_W-1:0]  i_key,
    input  wire               i_last,
    output logic              o_valid,
    input  wire               i_stall,
    output logic [KEY_W-1:0]  o_top_key,
    output logic [CNT_W-1:0]  o_top_count,
    output logic [TIE_W-1:0]  o_tie_count,
    output logic              o_dropped,
    input  wire               i_cfg_we,
    input  wire  [SIZE_W-1:0] i_cfg_data
);
    t_cmd cmd;
    t_sts sts;

    hfmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    hfmc_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (i_key),
        .i_last      (i_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_top_key   (o_top_key),
        .o_top_count (o_top_count),
        .o_tie_count (o_tie_count),
        .o_dropped   (o_dropped)
    );
endmodule
`default_nettype wire

// File: sim/hash_frequency_mode_counter_tb.sv
// testbench for the hash frequency mode counter: directed and random sets against a table predictor
`timescale 1ns / 1ps
`default_nettype none
module hash_frequency_mode_counter_tb
    import hfmc_pkg::*;
();

    localparam int TBL      = SLOTS_DEF;
    // scan of a full table, clearing pass and slack
    localparam int SETTLE   = 3 * TBL + 400;
    // every key a last key with a full scan, clear and drain, with margin
    localparam int LIMIT    = 8 * 1300 * SETTLE;
    localparam logic [KEY_W-1:0] KEY_TOP = 40'd999999999999;

    typedef struct packed {
        logic [KEY_W-1:0] top_key;
        logic [CNT_W-1:0] top_count;
        logic [TIE_W-1:0] tie_count;
        logic             dropped;
    } t_mode;

    class freq_board;
        logic [KEY_W-1:0] slot_key[TBL];
        int unsigned      slot_cnt[TBL];
        bit               lost;
        int unsigned      size_reg;
        t_mode            mode_q[$];
        int               errors;
        int               reports;
        int               drop_reports;

        function new();
            clear_table();
            size_reg = SIZE_RST;
            errors = 0;
            reports = 0;
            drop_reports = 0;
        endfunction

        function void clear_table();
            for (int i = 0; i < TBL; i++) begin
                slot_key[i] = '0;
                slot_cnt[i] = 0;
            end
            lost = 0;
        endfunction

        function int unsigned slots_used();
            if (size_reg == 0) return 1;
            if (size_reg > TBL) return TBL;
            return size_reg;
        endfunction

        function void tally(logic [KEY_W-1:0] k);
            int unsigned n;
            int unsigned pos;
            longint unsigned kk;
            n = slots_used();
            kk = k;
            pos = kk % n;
            for (int s = 0; s < n; s++) begin
                if (slot_cnt[pos] == 0) begin
                    slot_key[pos] = k;
                    slot_cnt[pos] = 1;
                    return;
                end
                if (slot_key[pos] == k) begin
                    if (slot_cnt[pos] < CNT_MAX) slot_cnt[pos]++;
                    return;
                end
                pos = (pos + 1 >= n) ? 0 : pos + 1;
            end
            lost = 1;
        endfunction

        // accepted key; a last key produces the expected mode report
        function void note_key(logic [KEY_W-1:0] k, logic lst);
            int unsigned n;
            int unsigned best;
            int unsigned ties;
            logic [KEY_W-1:0] best_key;
            bit have;
            t_mode m;
            tally(k);
            if (!lst) return;
            n = slots_used();
            best = 0;
            ties = 0;
            have = 0;
            best_key = '0;
            for (int i = 0; i < n; i++)
                if (slot_cnt[i] > best) best = slot_cnt[i];
            if (best != 0) begin
                for (int i = 0; i < n; i++) begin
                    if (slot_cnt[i] == best) begin
                        if (ties < TIE_MAX) ties++;
                        if (!have || slot_key[i] < best_key) begin
                            best_key = slot_key[i];
                            have = 1;
                        end
                    end
                end
            end
            m.top_key = best_key;
            m.top_count = best[CNT_W-1:0];
            m.tie_count = ties[TIE_W-1:0];
            m.dropped = lost;
            mode_q.push_back(m);
            clear_table();
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_mode(t_mode got);
            t_mode want;
            reports++;
            if (got.dropped) drop_reports++;
            if (mode_q.size() == 0) begin
                report("unexpected report, top_key", got.top_key, 0);
                return;
            end
            want = mode_q.pop_front();
            if (got.top_key !== want.top_key) report("top_key", got.top_key, want.top_key);
            if (got.top_count !== want.top_count)
                report("top_count", got.top_count, want.top_count);
            if (got.tie_count !== want.tie_count)
                report("tie_count", got.tie_count, want.tie_count);
            if (got.dropped !== want.dropped) report("dropped", got.dropped, want.dropped);
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [KEY_W-1:0]  i_key;
    logic              i_last;
    logic              o_valid;
    logic              i_stall;
    logic [KEY_W-1:0]  o_top_key;
    logic [CNT_W-1:0]  o_top_count;
    logic [TIE_W-1:0]  o_tie_count;
    logic              o_dropped;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_data;

    freq_board board;
    int send_idle_pct;
    int recv_stall_pct;
    int cycles;
    int keys_sent;

    hash_frequency_mode_counter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_key       (i_key),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_top_key   (o_top_key),
        .o_top_count (o_top_count),
        .o_tie_count (o_tie_count),
        .o_dropped   (o_dropped),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: check each transfer, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_mode({o_top_key, o_top_count, o_tie_count, o_dropped});
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task send_key(logic [KEY_W-1:0] k, logic lst);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_key <= k;
        i_last <= lst;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        board.note_key(k, lst);
        keys_sent++;
    endtask

    task stop_sending();
        i_valid <= 1'b0;
    endtask

    // wait out outstanding reports, then the scan and clearing pass
    task wait_drained();
        while (board.mode_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_size(logic [SIZE_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        board.size_reg = 32'(v);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function logic [KEY_W-1:0] any_key();
        case ($urandom_range(0, 3))
            0: any_key = KEY_W'({$urandom(), $urandom()});
            1: any_key = KEY_W'({$urandom(), $urandom()} % (64'(KEY_TOP) + 64'd1));
            2: any_key = KEY_W'($urandom_range(0, 63));
            default: any_key = KEY_W'($urandom_range(0, 8) * board.slots_used()
                                      + $urandom_range(0, 2));
        endcase
    endfunction

    // one set: mostly repeats from a small pool, ends with last
    task random_set();
        logic [KEY_W-1:0] pool[8];
        int len;
        int npool;
        bit noisy;
        len = $urandom_range(1, 40);
        npool = $urandom_range(1, 8);
        noisy = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < 8; i++) pool[i] = any_key();
        for (int i = 0; i < len; i++)
            send_key(noisy ? any_key() : pool[$urandom_range(0, npool - 1)], i == len - 1);
    endtask

    task random_phase(int sidle, int rstall, int nkeys);
        int goal;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        goal = keys_sent + nkeys;
        while (keys_sent < goal) begin
            if ($urandom_range(0, 5) == 0) begin
                stop_sending();
                wait_drained();
                case ($urandom_range(0, 6))
                    0: write_size(1);
                    1: write_size(2);
                    2: write_size(5);
                    3: write_size(16);
                    4: write_size(SIZE_W'(TBL));
                    5: write_size(13'h1FFF);
                    default: write_size(SIZE_W'($urandom_range(0, 13'h1FFF)));
                endcase
            end
            random_set();
        end
        stop_sending();
    endtask

    initial begin
        board = new();
        cycles = 0;
        keys_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_key = '0;
        i_last = 1'b0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default size: collision on home slot, extreme keys
        send_key('0, 0);
        send_key('0, 0);
        send_key('1, 0);
        send_key(KEY_TOP, 0);
        send_key(40'd4096, 0);
        send_key(40'd12345, 1);
        stop_sending();
        wait_drained();
        // single slot: second distinct key is dropped
        write_size(1);
        send_key(40'd5, 0);
        send_key(40'd5, 0);
        send_key(40'd7, 0);
        send_key(40'd5, 1);
        stop_sending();
        wait_drained();
        // zero size behaves as one slot
        write_size(0);
        send_key(40'd9, 1);
        stop_sending();
        wait_drained();
        // oversize clamps; two keys tie
        write_size(13'h1FFF);
        send_key(40'd77, 0);
        send_key(40'd33, 0);
        send_key(40'd77, 0);
        send_key(40'd33, 1);
        stop_sending();
        wait_drained();
        // probe wraps around a full table
        write_size(3);
        send_key(40'd2, 0);
        send_key(40'd5, 0);
        send_key(40'd8, 0);
        send_key(40'd9, 1);
        stop_sending();
        wait_drained();
        // size changed in the middle of a set
        write_size(7);
        send_key(40'd1, 0);
        send_key(40'd6, 0);
        stop_sending();
        wait_drained();
        write_size(2);
        send_key(40'd3, 1);
        stop_sending();
        wait_drained();

        random_phase(6, 64, 400);
        random_phase(64, 6, 400);
        random_phase(0, 0, 400);
        wait_drained();

        $display("covered %0d keys, %0d mode reports, %0d of them with drops",
                 keys_sent, board.reports, board.drop_reports);
        $display("table sizes from zero through oversize, idling on either side and none");
        if (board.errors == 0 && board.mode_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d reports missing", board.errors, board.mode_q.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/hfmc_pkg.sv
rtl/hfmc_ctrl.sv
rtl/hfmc_dp.sv
rtl/hash_frequency_mode_counter.sv
sim/hash_frequency_mode_counter_tb.sv
